// ----- rtl/core/lif_network_event_step_macros.svh -----
// Assertion macros for the LIF network event block.
// Used by the port checker; the macros expect i_clk and i_rst_n in scope.
`ifndef LIF_NETWORK_EVENT_STEP_MACROS_SVH
`define LIF_NETWORK_EVENT_STEP_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define LIFN_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lifn port check failed");

// Next-cycle implication, disabled while in reset.
`define LIFN_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lifn port check failed");

`endif

// ----- rtl/core/lifn_pkg.sv -----
// Shared types, constants and helpers for the LIF network event block.
// No dependencies; used by every module under rtl/core except lifn_checker.
package lifn_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int VW          = FRAC_BITS + 1;   // voltage, Q1.16 held in 17 bits
    localparam int CFG_W       = 16;
    localparam int CNT_W       = 7;
    localparam int IDX_W       = 6;
    localparam int FC_W        = 23;              // fire count times coupling step
    localparam int SW          = FC_W + 1;        // widest voltage sum
    localparam int TOT_W       = 32;
    localparam int MASK_W      = 64;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 136;
    localparam int APB_AW      = 4;
    localparam int APB_DW      = 32;

    localparam logic [VW-1:0] V_ONE = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [VW-1:0] V_MAX = '1;

    localparam logic [CFG_W-1:0] KICK_RST   = 16'd66;
    localparam logic [CFG_W-1:0] COUPLE_RST = 16'd1311;
    localparam logic [CNT_W-1:0] COUNT_RST  = 7'd64;

    localparam logic CMD_KICK = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    typedef enum logic [2:0] {
        OP_LOAD,
        OP_LEAK,
        OP_KICK,
        OP_CASC,
        OP_WRITE
    } t_op;

    typedef struct packed {
        logic [VW-1:0] v;
        logic          fire;
    } t_cell;

    typedef struct packed {
        logic [CFG_W-1:0] kick;
        logic [CFG_W-1:0] couple;
        logic [CNT_W-1:0] count;
    } t_cfg;

    typedef struct packed {
        t_op  op;
        logic act;
        logic hit;
    } t_head_ctl;

    typedef struct packed {
        t_cell slot;
        logic  trig;
        logic  fire_new;
    } t_head_out;

    function automatic logic [VW-1:0] sat_v(input logic [SW-1:0] x);
        if (x > SW'(V_MAX)) begin
            return V_MAX;
        end
        return x[VW-1:0];
    endfunction

endpackage

// ----- rtl/core/lifn_cell.sv -----
// One storage cell of the neuron ring: a voltage and a fired flag.
// Depends on lifn_pkg for the cell type.
module lifn_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_shift,
    input  lifn_pkg::t_cell i_d,
    output lifn_pkg::t_cell o_q
);

    lifn_pkg::t_cell r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

// ----- rtl/core/lifn_head.sv -----
// Update unit at the head of the neuron ring: load, leak, kick, cascade, write back.
// Depends on lifn_pkg for types and the saturation helper.
module lifn_head (
    input  lifn_pkg::t_head_ctl              i_ctl,
    input  lifn_pkg::t_cell                  i_cell,
    input  logic [lifn_pkg::VW-1:0]          i_decay,
    input  logic [lifn_pkg::VW-1:0]          i_load,
    input  logic [lifn_pkg::CFG_W-1:0]       i_kick,
    input  logic [lifn_pkg::FC_W-1:0]        i_fc,
    output lifn_pkg::t_head_out              o_out
);

    logic [2*lifn_pkg::VW-1:0]                  w_prod;
    logic [2*lifn_pkg::VW-1-lifn_pkg::FRAC_BITS:0] w_leak;
    logic [lifn_pkg::VW-1:0]                    w_kick_sat;
    logic [lifn_pkg::SW-1:0]                    w_couple;

    always_comb begin
        w_prod     = i_cell.v * i_decay;
        w_leak     = w_prod[2*lifn_pkg::VW-1:lifn_pkg::FRAC_BITS];
        w_kick_sat = lifn_pkg::sat_v(lifn_pkg::SW'(i_cell.v) + lifn_pkg::SW'(i_kick));
        w_couple   = lifn_pkg::SW'(i_cell.v) + lifn_pkg::SW'(i_fc);

        o_out.slot     = i_cell;
        o_out.trig     = 1'b0;
        o_out.fire_new = 1'b0;

        case (i_ctl.op)
            lifn_pkg::OP_LOAD: begin
                if (i_ctl.hit) begin
                    o_out.slot.v = i_load;
                end
            end
            lifn_pkg::OP_LEAK: begin
                if (i_ctl.act) begin
                    o_out.slot.v = lifn_pkg::sat_v(lifn_pkg::SW'(w_leak));
                end
            end
            lifn_pkg::OP_KICK: begin
                if (i_ctl.hit) begin
                    o_out.slot.v    = w_kick_sat;
                    o_out.slot.fire = (w_kick_sat > lifn_pkg::V_ONE);
                    o_out.trig      = (w_kick_sat > lifn_pkg::V_ONE);
                end
            end
            lifn_pkg::OP_CASC: begin
                // fire once the couplings received so far lift it to threshold
                if (i_ctl.act && !i_cell.fire && (w_couple >= lifn_pkg::SW'(lifn_pkg::V_ONE)))
                begin
                    o_out.slot.fire = 1'b1;
                    o_out.fire_new  = 1'b1;
                end
            end
            lifn_pkg::OP_WRITE: begin
                if (i_cell.fire) begin
                    o_out.slot.v    = '0;
                    o_out.slot.fire = 1'b0;
                end else if (i_ctl.act) begin
                    o_out.slot.v = lifn_pkg::sat_v(w_couple);
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ----- rtl/core/lifn_regs.sv -----
// APB register file: kick size, coupling step, neuron count.
// Depends on lifn_pkg for widths, reset values and the config struct.
module lifn_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lifn_pkg::APB_AW-1:0]   paddr,
    input  logic [lifn_pkg::APB_DW-1:0]   pwdata,
    output logic [lifn_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output lifn_pkg::t_cfg                o_cfg
);

    localparam logic [1:0] REG_KICK   = 2'd0;
    localparam logic [1:0] REG_COUPLE = 2'd1;
    localparam logic [1:0] REG_COUNT  = 2'd2;

    lifn_pkg::t_cfg r_cfg;
    logic           w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kick   <= lifn_pkg::KICK_RST;
            r_cfg.couple <= lifn_pkg::COUPLE_RST;
            r_cfg.count  <= lifn_pkg::COUNT_RST;
        end else if (w_wr) begin
            case (paddr[3:2])
                REG_KICK:   r_cfg.kick   <= pwdata[lifn_pkg::CFG_W-1:0];
                REG_COUPLE: r_cfg.couple <= pwdata[lifn_pkg::CFG_W-1:0];
                REG_COUNT:  r_cfg.count  <= pwdata[lifn_pkg::CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_KICK:   prdata = lifn_pkg::APB_DW'(r_cfg.kick);
            REG_COUPLE: prdata = lifn_pkg::APB_DW'(r_cfg.couple);
            REG_COUNT:  prdata = lifn_pkg::APB_DW'(r_cfg.count);
            default:    prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/core/lif_network_event_step.sv -----
// Top level of the all-to-all LIF network event block: cell ring, head unit, control.
// Depends on lifn_pkg, lifn_cell, lifn_head and lifn_regs.
//
//  port group  dir  handshake                 contents
//  s_axis      in   tvalid/tready             one request: load or kick
//  m_axis      out  tvalid/tready             one result per request
//  apb         in   psel/penable/pready       three config registers
//
// The voltages circulate through a ring of NEURONS cells. A load takes one pass.
// A kick takes a leak pass and ends there if the neuron is unused; else a kick pass,
// ending there if it does not fire; else P >= 1 cascade passes, one more pass
// for each round in which new neurons reach threshold, and then a write pass.
// One request at a time; a finished result waits in the output register while the
// next request is taken. Reset zeroes all voltages, counters and config to defaults.
module lif_network_event_step #(
    parameter int NEURONS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // neuron[5:0], decay[22:6], load_value[39:23]
    input  logic [lifn_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // cmd[0]
    input  logic [0:0]                          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // cascade_size[6:0], fire_mask[70:7], event_total[102:71], spike_total[134:103]
    output logic [lifn_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // fired[0]
    output logic [0:0]                          m_axis_tuser,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lifn_pkg::APB_AW-1:0]         paddr,
    input  logic [lifn_pkg::APB_DW-1:0]         pwdata,
    output logic [lifn_pkg::APB_DW-1:0]         prdata,
    output logic                                pready
);

    localparam int PW  = $clog2(NEURONS);
    localparam int NCW = $clog2(NEURONS + 1);
    localparam logic [PW-1:0]             POS_LAST = PW'(NEURONS - 1);
    localparam logic [lifn_pkg::CNT_W-1:0] N_MAX   = lifn_pkg::CNT_W'(NEURONS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PASS,
        S_DONE
    } t_state;

    t_state                          r_state;
    lifn_pkg::t_op                   r_op;
    logic [PW-1:0]                   r_pos;
    logic                            r_trig;
    logic                            r_changed;
    logic [NCW-1:0]                  r_f;
    logic [lifn_pkg::FC_W-1:0]       r_fc;
    logic [NEURONS-1:0]              r_mask;
    logic [lifn_pkg::TOT_W-1:0]      r_event;
    logic [lifn_pkg::TOT_W-1:0]      r_spike;
    logic                            r_out_valid;
    logic [lifn_pkg::OUT_TDATA_W-1:0] r_out_data;
    logic                            r_out_user;

    logic [lifn_pkg::IDX_W-1:0]      r_idx;
    logic [lifn_pkg::VW-1:0]         r_decay;
    logic [lifn_pkg::VW-1:0]         r_load;

    lifn_pkg::t_cfg                  w_cfg;
    logic [lifn_pkg::CNT_W-1:0]      w_n_eff;
    logic                            w_last;
    logic                            w_idx_ok;
    logic                            w_shift;
    logic                            w_in_cmd;
    lifn_pkg::t_head_ctl             w_ctl;
    lifn_pkg::t_head_out             w_head;
    lifn_pkg::t_cell                 w_q [NEURONS];
    lifn_pkg::t_cell                 w_d [NEURONS];

    lifn_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // clamp the configured count into 1..NEURONS
    always_comb begin
        if (w_cfg.count == '0) begin
            w_n_eff = lifn_pkg::CNT_W'(1);
        end else if (w_cfg.count > N_MAX) begin
            w_n_eff = N_MAX;
        end else begin
            w_n_eff = w_cfg.count;
        end
    end

    assign w_in_cmd  = s_axis_tuser[0];
    assign w_last    = (r_pos == POS_LAST);
    assign w_idx_ok  = (lifn_pkg::CNT_W'(r_idx) < w_n_eff);
    assign w_shift   = (r_state == S_PASS);

    assign w_ctl.op  = r_op;
    assign w_ctl.act = (lifn_pkg::CNT_W'(r_pos) < w_n_eff);
    assign w_ctl.hit = (lifn_pkg::CNT_W'(r_pos) == lifn_pkg::CNT_W'(r_idx));

    lifn_head u_head (
        .i_ctl   (w_ctl),
        .i_cell  (w_q[0]),
        .i_decay (r_decay),
        .i_load  (r_load),
        .i_kick  (w_cfg.kick),
        .i_fc    (r_fc),
        .o_out   (w_head)
    );

    // ring: each cell takes its upper neighbor, the last cell takes the head result
    for (genvar k = 0; k < NEURONS; k++) begin : g_ring
        if (k == NEURONS - 1) begin : g_tail
            assign w_d[k] = w_head.slot;
        end else begin : g_link
            assign w_d[k] = w_q[k+1];
        end
        lifn_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_d     (w_d[k]),
            .o_q     (w_q[k])
        );
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    // capture request payload
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_idx   <= s_axis_tdata[lifn_pkg::IDX_W-1:0];
            r_decay <= s_axis_tdata[lifn_pkg::IDX_W+lifn_pkg::VW-1:lifn_pkg::IDX_W];
            r_load  <= s_axis_tdata[lifn_pkg::IDX_W+2*lifn_pkg::VW-1:
                                    lifn_pkg::IDX_W+lifn_pkg::VW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= lifn_pkg::OP_LOAD;
            r_pos       <= '0;
            r_trig      <= 1'b0;
            r_changed   <= 1'b0;
            r_f         <= '0;
            r_fc        <= '0;
            r_mask      <= '0;
            r_event     <= '0;
            r_spike     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // drop the result once taken, unless a new one replaces it this cycle
            if (r_out_valid && m_axis_tready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_pos     <= '0;
                        r_trig    <= 1'b0;
                        r_changed <= 1'b0;
                        r_f       <= '0;
                        r_fc      <= '0;
                        r_mask    <= '0;
                        r_op      <= (w_in_cmd == lifn_pkg::CMD_LOAD) ?
                                     lifn_pkg::OP_LOAD : lifn_pkg::OP_LEAK;
                        r_state   <= S_PASS;
                    end
                end
                S_PASS: begin
                    r_pos <= w_last ? '0 : r_pos + PW'(1);
                    if (w_head.trig) begin
                        r_trig <= 1'b1;
                    end
                    if (w_head.fire_new) begin
                        if (!w_last) begin
                            r_changed <= 1'b1;
                        end
                        r_f       <= r_f + NCW'(1);
                        r_fc      <= r_fc + lifn_pkg::FC_W'(w_cfg.couple);
                    end
                    if (r_op == lifn_pkg::OP_WRITE) begin
                        r_mask[r_pos] <= w_q[0].fire;
                    end
                    if (w_last) begin
                        case (r_op)
                            lifn_pkg::OP_LOAD: begin
                                r_state <= S_DONE;
                            end
                            lifn_pkg::OP_LEAK: begin
                                if (w_idx_ok) begin
                                    r_op <= lifn_pkg::OP_KICK;
                                end else begin
                                    r_state <= S_DONE;
                                end
                            end
                            lifn_pkg::OP_KICK: begin
                                // kicked neuron above threshold counts as the first firing
                                if (r_trig || w_head.trig) begin
                                    r_op      <= lifn_pkg::OP_CASC;
                                    r_f       <= NCW'(1);
                                    r_fc      <= lifn_pkg::FC_W'(w_cfg.couple);
                                    r_changed <= 1'b0;
                                    r_event   <= r_event + lifn_pkg::TOT_W'(1);
                                end else begin
                                    r_state <= S_DONE;
                                end
                            end
                            lifn_pkg::OP_CASC: begin
                                // repeat the pass until one adds no firing
                                if (r_changed || w_head.fire_new) begin
                                    r_changed <= 1'b0;
                                end else begin
                                    r_op <= lifn_pkg::OP_WRITE;
                                end
                            end
                            lifn_pkg::OP_WRITE: begin
                                r_spike <= r_spike + lifn_pkg::TOT_W'(r_f);
                                r_state <= S_DONE;
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_user  <= r_trig;
                        r_out_data  <= {1'b0, r_spike, r_event,
                                        lifn_pkg::MASK_W'(r_mask),
                                        lifn_pkg::CNT_W'(r_f)};
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- rtl/core/lifn_checker.sv -----
// Port-level checker for the LIF network event block, bound to the top level.
// Depends on lif_network_event_step_macros.svh for the assertion macros.
`include "lif_network_event_step_macros.svh"

module lifn_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [135:0] m_axis_tdata,
    input logic [0:0]   m_axis_tuser
);

    // one request in flight: ready drops right after a request is taken
    `LIFN_ASSERT_NXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // a result without firing carries no cascade
    `LIFN_ASSERT_IMP(a_quiet_result, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[6:0] == 7'd0)

    // a firing result has at least the kicked neuron
    `LIFN_ASSERT_IMP(a_cascade_nonempty, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[6:0] != 7'd0)

    // cascade size equals the number of mask bits
    `LIFN_ASSERT_IMP(a_size_is_popcount, m_axis_tvalid, $countones(m_axis_tdata[70:7]) == m_axis_tdata[6:0])

    // hold a stalled result
    `LIFN_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind lif_network_event_step lifn_checker u_lifn_checker (.*);

// ----- test/tb.sv -----
// Testbench for lif_network_event_step: drives load and kick requests, programs the
// three APB registers and scores every result against a cycle-free network predictor.
// Depends on lifn_pkg and the lif_network_event_step RTL.
`timescale 1ns / 100ps

module tb;
    import lifn_pkg::*;

    localparam int NEURONS     = 64;
    localparam int HOLD_CYCLES = 3000;
    localparam int SETTLE      = 4 * NEURONS + 8;

    typedef enum int unsigned {
        REG_KICK_SIZE,
        REG_COUPLING_STEP,
        REG_NEURON_COUNT
    } t_reg;

    typedef struct packed {
        logic        fired;
        logic [6:0]  size;
        logic [63:0] mask;
        logic [31:0] events;
        logic [31:0] spikes;
    } t_outcome;

    // Network predictor plus the queue of outcomes still owed by the block.
    class network_tracker;
        logic [VW-1:0] volts [NEURONS];
        logic [31:0]   tally [NEURONS];
        logic [31:0]   events;
        logic [31:0]   spikes;
        logic [15:0]   kick;
        logic [15:0]   couple;
        logic [6:0]    count;
        t_outcome      awaited[$];
        int            errors;

        function new();
            foreach (volts[i]) begin
                volts[i] = '0;
                tally[i] = '0;
            end
            events = '0;
            spikes = '0;
            kick   = 16'd66;
            couple = 16'd1311;
            count  = 7'd64;
            errors = 0;
        endfunction

        function void set_reg(t_reg r, logic [31:0] value);
            case (r)
                REG_KICK_SIZE:     kick   = value[15:0];
                REG_COUPLING_STEP: couple = value[15:0];
                REG_NEURON_COUNT:  count  = value[6:0];
                default: ;
            endcase
        endfunction

        function int active_neurons();
            if (count == 0) return 1;
            if (count > NEURONS) return NEURONS;
            return count;
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction

        function logic [VW-1:0] clamp(logic [33:0] x);
            return (x > 34'(V_MAX)) ? V_MAX : x[VW-1:0];
        endfunction

        function void note_request(logic cmd, logic [5:0] idx, logic [16:0] decay,
                                   logic [16:0] load);
            t_outcome    res;
            logic [63:0] locked;
            logic [63:0] pending;
            int          n;
            int          cur;
            res = '0;
            n = active_neurons();
            if (cmd == CMD_LOAD) begin
                volts[idx] = clamp(34'(load));
            end else begin
                for (int i = 0; i < n; i++) begin
                    volts[i] = clamp((34'(volts[i]) * 34'(decay)) >> FRAC_BITS);
                end
                if (idx < n) begin
                    volts[idx] = clamp(34'(volts[idx]) + 34'(kick));
                    if (volts[idx] > V_ONE) begin
                        events++;
                        locked  = 64'd1 << idx;
                        pending = locked;
                        while (pending != 0) begin
                            // lowest pending neuron fires next
                            cur = 0;
                            while (!pending[cur]) cur++;
                            pending[cur] = 1'b0;
                            spikes++;
                            tally[cur]++;
                            res.size++;
                            volts[cur] = '0;
                            for (int i = 0; i < n; i++) begin
                                if (!locked[i]) begin
                                    volts[i] = clamp(34'(volts[i]) + 34'(couple));
                                    if (volts[i] >= V_ONE) begin
                                        locked[i]  = 1'b1;
                                        pending[i] = 1'b1;
                                    end
                                end
                            end
                        end
                        res.fired = 1'b1;
                        res.mask  = locked;
                    end
                end
            end
            res.events = events;
            res.spikes = spikes;
            awaited.insert(awaited.size(), res);
        endfunction

        function void check_field(string label, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s expected %0h actual %0h", $time, label, want, got);
            end
        endfunction

        function void check_result(logic [0:0] user, logic [OUT_TDATA_W-1:0] data);
            t_outcome want;
            if (awaited.size() == 0) begin
                errors++;
                $display("%0t: unexpected result expected none actual %0h_%0h",
                         $time, user, data);
                return;
            end
            want = awaited.pop_front();
            check_field("fired", 64'(want.fired), 64'(user[0]));
            check_field("cascade_size", 64'(want.size), 64'(data[6:0]));
            check_field("fire_mask", want.mask, data[70:7]);
            check_field("event_total", 64'(want.events), 64'(data[102:71]));
            check_field("spike_total", 64'(want.spikes), 64'(data[134:103]));
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // neuron[5:0], decay[22:6], load_value[39:23]
    logic [0:0]             s_axis_tuser = '0;   // cmd[0]
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // cascade_size[6:0], fire_mask[70:7],
                                                 // event_total[102:71], spike_total[134:103]
    logic [0:0]             m_axis_tuser;        // fired[0]
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [APB_AW-1:0]      paddr = '0;
    logic [APB_DW-1:0]      pwdata = '0;
    logic [APB_DW-1:0]      prdata;
    logic                   pready;

    network_tracker board = new();
    int send_idle_pct = 6;
    int recv_idle_pct = 64;
    int hold_ticket   = 0;

    lif_network_event_step #(.NEURONS(NEURONS)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Result side: score accepted results, stall at random or for a requested hold-off.
    initial begin
        int served;
        int hold_left;
        served    = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                board.check_result(m_axis_tuser, m_axis_tdata);
            end
            if (hold_ticket != served) begin
                served    = hold_ticket;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_request(input logic cmd, input logic [5:0] idx,
                                input logic [16:0] decay, input logic [16:0] load);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {load, decay, idx};
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_request(cmd, idx, decay, load);
    endtask

    // Drop the request line and hold until every owed result has come back.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (board.outstanding() != 0);
    endtask

    // Write one register, then read it back in a back-to-back transfer.
    task automatic program_reg(input t_reg r, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(4 * r);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        board.set_reg(r, value);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== value) begin
            board.errors++;
            $display("%0t: register %s expected %0h actual %0h", $time, r.name(), value,
                     prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic random_settings();
        logic [15:0] k;
        logic [15:0] c;
        logic [6:0]  cnt;
        case ($urandom_range(3))
            0:       k = 16'd0;
            1:       k = 16'hFFFF;
            2:       k = 16'($urandom_range(2000));
            default: k = 16'($urandom);
        endcase
        case ($urandom_range(3))
            0:       c = 16'd0;
            1:       c = 16'hFFFF;
            2:       c = 16'($urandom_range(4000));
            default: c = 16'($urandom);
        endcase
        case ($urandom_range(5))
            0:       cnt = 7'd0;
            1:       cnt = 7'd1;
            2:       cnt = 7'd64;
            3:       cnt = 7'($urandom_range(127, 65));
            4:       cnt = 7'($urandom_range(64, 2));
            default: cnt = 7'($urandom_range(12, 2));
        endcase
        program_reg(REG_KICK_SIZE, 32'(k));
        program_reg(REG_COUPLING_STEP, 32'(c));
        program_reg(REG_NEURON_COUNT, 32'(cnt));
    endtask

    // Loads, mostly near threshold, and kicks, mostly with little leak, so cascades keep happening.
    task automatic random_item();
        int          n;
        logic [5:0]  idx;
        logic [16:0] dec;
        logic [16:0] ld;
        n   = board.active_neurons();
        idx = ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(n - 1));
        dec = 17'($urandom);
        ld  = 17'($urandom);
        if ($urandom_range(99) < 40) begin
            if ($urandom_range(3) != 0) ld = 17'(65636 - $urandom_range(3000));
            send_request(CMD_LOAD, idx, dec, ld);
        end else begin
            case ($urandom_range(3))
                0:       ;
                1:       dec = 17'(65536 - $urandom_range(2000));
                default: dec = 17'd65536;
            endcase
            send_request(CMD_KICK, idx, dec, ld);
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: saturation, thresholds, leak extremes, unused neurons, count edges.
        send_request(CMD_LOAD, 6'd0, 17'($urandom), 17'h1FFFF);
        send_request(CMD_LOAD, 6'd5, 17'($urandom), 17'd65500);
        send_request(CMD_LOAD, 6'd63, 17'($urandom), 17'd0);
        send_request(CMD_KICK, 6'd5, 17'd65536, 17'($urandom));
        // kick landing exactly on 1.0 does not fire
        send_request(CMD_LOAD, 6'd2, 17'($urandom), 17'd65470);
        send_request(CMD_KICK, 6'd2, 17'd65536, 17'($urandom));
        // coupling landing exactly on 1.0 does fire
        send_request(CMD_LOAD, 6'd3, 17'($urandom), 17'd64225);
        send_request(CMD_LOAD, 6'd4, 17'($urandom), 17'd65536);
        send_request(CMD_KICK, 6'd4, 17'd65536, 17'($urandom));
        send_request(CMD_KICK, 6'd1, 17'd0, 17'($urandom));
        // decay above 1.0 saturates
        send_request(CMD_LOAD, 6'd7, 17'($urandom), 17'd70000);
        send_request(CMD_KICK, 6'd7, 17'h1FFFF, 17'($urandom));
        send_request(CMD_KICK, 6'd9, 17'd65536, 17'($urandom));

        drain();
        program_reg(REG_NEURON_COUNT, 32'd1);
        program_reg(REG_KICK_SIZE, 32'hFFFF);
        program_reg(REG_COUPLING_STEP, 32'd0);
        send_request(CMD_KICK, 6'd10, 17'd65536, 17'($urandom));
        send_request(CMD_LOAD, 6'd0, 17'($urandom), 17'd2);
        send_request(CMD_KICK, 6'd0, 17'd65536, 17'($urandom));
        send_request(CMD_LOAD, 6'd40, 17'($urandom), 17'd5000);

        drain();
        program_reg(REG_NEURON_COUNT, 32'd0);
        program_reg(REG_KICK_SIZE, 32'd0);
        program_reg(REG_COUPLING_STEP, 32'hFFFF);
        send_request(CMD_LOAD, 6'd0, 17'($urandom), 17'd65537);
        send_request(CMD_KICK, 6'd0, 17'd65536, 17'($urandom));

        drain();
        program_reg(REG_NEURON_COUNT, 32'd127);
        program_reg(REG_KICK_SIZE, 32'd66);
        send_request(CMD_LOAD, 6'd63, 17'($urandom), 17'd65536);
        send_request(CMD_KICK, 6'd63, 17'd65536, 17'($urandom));

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 6;
                    recv_idle_pct = 64;
                end
                1: begin
                    send_idle_pct = 64;
                    recv_idle_pct = 6;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int blk = 0; blk < 4; blk++) begin
                drain();
                random_settings();
                // stall the result side long enough for requests to back up
                if (phase == 1 && blk == 2) hold_ticket <= hold_ticket + 1;
                repeat (80) random_item();
            end
        end

        drain();
        repeat (SETTLE) @(posedge i_clk);
        if (board.errors == 0 && board.outstanding() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #80_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
